// ===== hw/rtl/mpoc_pkg.sv =====
// Package for the multi-pattern overlap counter.
// Holds the operation codes, the input item layout and the decoded command.
// No dependencies; used by every module of the block.
`default_nettype none

package mpoc_pkg;

  typedef enum logic [2:0] {
    OP_WR_BYTE = 3'd0,
    OP_WR_LEN  = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_TEXT    = 3'd3,
    OP_READ    = 3'd4
  } op_e;

  localparam int unsigned OUT_COUNT_W = 32;

  typedef struct packed {
    logic [2:0] operation;
    logic [2:0] pattern_slot;
    logic [3:0] byte_position;
    logic [7:0] data_byte;
    logic [4:0] pattern_length;
  } item_t;

  typedef struct packed {
    logic       wr_byte;
    logic       wr_len;
    logic       clear;
    logic       text;
    logic       read;
    logic [2:0] slot;
    logic [3:0] pos;
    logic [7:0] data;
    logic [4:0] len;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_pattern_overlap_counter_core.sv =====
// Top level of the multi-pattern overlap counter.
// Depends on mpoc_pkg, mpoc_match and mpoc_counts.
//
// Items arrive on the slave stream: tuser carries the operation, tdata the
// slot, byte position, data byte and pattern length. Pattern byte and length
// writes fill the pattern slots, a clear empties the history and the counts,
// a text byte shifts into the history and bumps the saturating count of
// every enabled slot whose pattern ends at that byte, overlaps included.
// A read sends one beat on the master stream: tdata is the count, tuser the
// slot. Other operations give no beat.
// An accepted beat is held in an input register and executed from there; a read
// waits there while the output register holds a result the receiver is not taking,
// and its own result is then registered in the output register for the receiver.
// One beat is accepted every cycle; the only stall is a read that meets a
// result still held in the output register while the receiver is stalled.
// Other operations keep flowing past such a waiting result.
// Reset clears the lengths (all slots disabled), history, bytes seen and
// counts; pattern bytes are undefined until written.
`default_nettype none

module multi_pattern_overlap_counter_core #(
  parameter int NUM_PATTERNS    = 8,
  parameter int MAX_PATTERN_LEN = 16,
  parameter int COUNT_WIDTH     = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // pattern_slot [2:0], byte_position [6:3], data_byte [14:7],
  // pattern_length [19:15], zero [23:20]
  input  wire logic [23:0] s_axis_tdata_i,
  // operation [2:0]
  input  wire logic [2:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // count_value [31:0]
  output logic [31:0]      m_axis_tdata_o,
  // count_slot [2:0]
  output logic [2:0]       m_axis_tuser_o
);

  logic                    in_valid_q;
  mpoc_pkg::item_t         item_q;
  logic                    is_read;
  logic                    adv;
  mpoc_pkg::cmd_t          cmd;
  logic [NUM_PATTERNS-1:0] hit;
  logic                    out_valid;

  assign is_read = (item_q.operation == mpoc_pkg::OP_READ);
  assign adv = in_valid_q && (!is_read || !out_valid || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.operation      <= s_axis_tuser_i;
      item_q.pattern_slot   <= s_axis_tdata_i[2:0];
      item_q.byte_position  <= s_axis_tdata_i[6:3];
      item_q.data_byte      <= s_axis_tdata_i[14:7];
      item_q.pattern_length <= s_axis_tdata_i[19:15];
    end
  end

  always_comb begin
    cmd.wr_byte = 1'b0;
    cmd.wr_len  = 1'b0;
    cmd.clear   = 1'b0;
    cmd.text    = 1'b0;
    cmd.read    = 1'b0;
    cmd.slot    = item_q.pattern_slot;
    cmd.pos     = item_q.byte_position;
    cmd.data    = item_q.data_byte;
    cmd.len     = item_q.pattern_length;
    if (adv) begin
      unique case (item_q.operation)
        mpoc_pkg::OP_WR_BYTE: cmd.wr_byte = 1'b1;
        mpoc_pkg::OP_WR_LEN:  cmd.wr_len  = 1'b1;
        mpoc_pkg::OP_CLEAR:   cmd.clear   = 1'b1;
        mpoc_pkg::OP_TEXT:    cmd.text    = 1'b1;
        mpoc_pkg::OP_READ:    cmd.read    = 1'b1;
        default: ;
      endcase
    end
  end

  mpoc_match #(
    .NUM_PATTERNS    (NUM_PATTERNS),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .hit_o  (hit)
  );

  mpoc_counts #(
    .NUM_PATTERNS (NUM_PATTERNS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_counts (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .hit_i      (hit),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (out_valid),
    .m_count_o  (m_axis_tdata_o),
    .m_slot_o   (m_axis_tuser_o)
  );

  assign m_axis_tvalid_o = out_valid;

  a_read_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_read) |=> m_axis_tvalid_o)
    else $error("A read left no result beat.");

  a_beat_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(adv && is_read))
    else $error("A result beat appeared without a read.");

  a_stall_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && is_read && out_valid && !m_axis_tready_i))
    else $error("Input stalled without a blocked read.");

endmodule

`default_nettype wire

// ===== hw/rtl/mpoc_match.sv =====
// Pattern store, length table, text history and parallel match logic.
// Depends on mpoc_pkg for the decoded command.
`default_nettype none

module mpoc_match #(
  parameter int NUM_PATTERNS    = 8,
  parameter int MAX_PATTERN_LEN = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mpoc_pkg::cmd_t      cmd_i,
  output logic [NUM_PATTERNS-1:0]  hit_o
);

  localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);

  logic [7:0]       pat_q  [NUM_PATTERNS][MAX_PATTERN_LEN];
  logic [LEN_W-1:0] len_q  [NUM_PATTERNS];
  logic [7:0]       hist_q [MAX_PATTERN_LEN];
  logic [7:0]       hist_n [MAX_PATTERN_LEN];
  logic [LEN_W-1:0] seen_q;
  logic [LEN_W-1:0] seen_n;
  logic [LEN_W-1:0] len_sat;
  logic [MAX_PATTERN_LEN:0] hit_len [NUM_PATTERNS];

  assign len_sat = (32'(cmd_i.len) > MAX_PATTERN_LEN) ? LEN_W'(MAX_PATTERN_LEN)
                                                      : LEN_W'(cmd_i.len);

  always_comb begin
    hist_n[0] = cmd_i.data;
    for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
      hist_n[i] = hist_q[i-1];
    end
    seen_n = (32'(seen_q) == MAX_PATTERN_LEN) ? seen_q : seen_q + LEN_W'(1);
  end

  // For every candidate length the pattern is aligned with the newest bytes.
  always_comb begin
    logic ok;
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      hit_len[s][0] = 1'b0;
      for (int l = 1; l <= MAX_PATTERN_LEN; l++) begin
        ok = 1'b1;
        for (int i = 0; i < l; i++) begin
          ok = ok & (pat_q[s][l-1-i] == hist_n[i]);
        end
        hit_len[s][l] = ok;
      end
      hit_o[s] = (len_q[s] != '0) && (seen_n >= len_q[s]) && hit_len[s][len_q[s]];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
        if (cmd_i.wr_byte && (32'(cmd_i.slot) == s) && (32'(cmd_i.pos) == p)) begin
          pat_q[s][p] <= cmd_i.data;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        len_q[s] <= '0;
      end
      for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
        hist_q[i] <= '0;
      end
      seen_q <= '0;
    end else begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        if (cmd_i.wr_len && (32'(cmd_i.slot) == s)) begin
          len_q[s] <= len_sat;
        end
      end
      if (cmd_i.clear) begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
          hist_q[i] <= '0;
        end
        seen_q <= '0;
      end else if (cmd_i.text) begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
          hist_q[i] <= hist_n[i];
        end
        seen_q <= seen_n;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mpoc_counts.sv =====
// Saturating match counters and the registered read-out beat.
// Depends on mpoc_pkg for the decoded command and the output count width.
`default_nettype none

module mpoc_counts #(
  parameter int NUM_PATTERNS = 8,
  parameter int COUNT_WIDTH  = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire mpoc_pkg::cmd_t                       cmd_i,
  input  wire logic [NUM_PATTERNS-1:0]              hit_i,
  input  wire logic                                 m_tready_i,
  output logic                                      m_tvalid_o,
  output logic [mpoc_pkg::OUT_COUNT_W-1:0]          m_count_o,
  output logic [2:0]                                m_slot_o
);

  localparam int SIDX_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

  logic [COUNT_WIDTH-1:0]           cnt_q [NUM_PATTERNS];
  logic [SIDX_W-1:0]                rd_idx;
  logic                             rd_ok;
  logic [COUNT_WIDTH-1:0]           rd_cnt;
  logic [mpoc_pkg::OUT_COUNT_W-1:0] rd_sat;
  logic                             out_valid_q;
  logic [mpoc_pkg::OUT_COUNT_W-1:0] out_cnt_q;
  logic [2:0]                       out_slot_q;

  assign rd_idx = SIDX_W'(cmd_i.slot);
  assign rd_ok  = 32'(cmd_i.slot) < NUM_PATTERNS;
  assign rd_cnt = rd_ok ? cnt_q[rd_idx] : '0;

  generate
    if (COUNT_WIDTH > mpoc_pkg::OUT_COUNT_W) begin : g_sat
      assign rd_sat = (|rd_cnt[COUNT_WIDTH-1:mpoc_pkg::OUT_COUNT_W]) ? '1
                      : rd_cnt[mpoc_pkg::OUT_COUNT_W-1:0];
    end else begin : g_ext
      assign rd_sat = mpoc_pkg::OUT_COUNT_W'(rd_cnt);
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        cnt_q[s] <= '0;
      end
    end else begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        if (cmd_i.clear) begin
          cnt_q[s] <= '0;
        end else if (cmd_i.text && hit_i[s] && !(&cnt_q[s])) begin
          cnt_q[s] <= cnt_q[s] + COUNT_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.read) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      out_cnt_q  <= rd_sat;
      out_slot_q <= cmd_i.slot;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_count_o  = out_cnt_q;
  assign m_slot_o   = out_slot_q;

endmodule

`default_nettype wire

// ===== test/tb_multi_pattern_overlap_counter_core.sv =====
// Self-checking testbench for multi_pattern_overlap_counter_core.
// Depends on mpoc_pkg; a shadow counter predicts every count read beat, and a monitor checks
// each output beat against it under random bursts, receiver stalls and one long hold-off.
`timescale 1ns / 100ps

module tb_multi_pattern_overlap_counter_core;

  localparam int NUM_PATTERNS    = 8;
  localparam int MAX_PATTERN_LEN = 16;
  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 8;
  localparam int PLANNED_ITEMS   = 1350;
  localparam int DRAIN_CYCLES    = 16;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_START      = 1000;
  localparam int HOLD_CYCLES     = 400;
  localparam int OP_CODE_MAX     = 7;
  localparam int REPORT_LINES    = 50;

  typedef struct packed {
    logic [31:0] count;
    logic [2:0]  slot;
  } count_beat_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid   = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata    = '0;
  logic [2:0]  s_axis_tuser    = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready   = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  multi_pattern_overlap_counter_core #(
    .NUM_PATTERNS   (NUM_PATTERNS),
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN),
    .COUNT_WIDTH    (32)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  always #CLK_HALF clk_i = ~clk_i;

  mpoc_pkg::item_t command_queue[$];
  count_beat_t     expected_counts[$];
  int              err_count      = 0;
  int              cycle_count    = 0;
  int              beats_in       = 0;
  int              text_beats     = 0;
  int              reads_checked  = 0;
  int              stall_cycles   = 0;
  int              planned_count  = 0;

  // Stimulus-side view of the slots, so that no enabled slot ever covers an unwritten byte.
  logic [7:0]  plan_pattern [NUM_PATTERNS][MAX_PATTERN_LEN];
  logic [15:0] plan_written [NUM_PATTERNS];
  int          plan_len     [NUM_PATTERNS];

  // Shadow of the block's state, advanced on every accepted input beat.
  logic [7:0]  shadow_pattern [NUM_PATTERNS][MAX_PATTERN_LEN];
  logic [4:0]  shadow_len     [NUM_PATTERNS];
  logic [7:0]  shadow_history [MAX_PATTERN_LEN];
  int          shadow_seen;
  logic [31:0] shadow_count   [NUM_PATTERNS];

  task automatic report_mismatch(input string msg);
    if (err_count < REPORT_LINES) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
    err_count++;
  endtask

  task automatic push_item(input logic [2:0] op, input logic [2:0] slot, input logic [3:0] pos,
                           input logic [7:0] data, input logic [4:0] len);
    mpoc_pkg::item_t it;
    it.operation      = op;
    it.pattern_slot   = slot;
    it.byte_position  = pos;
    it.data_byte      = data;
    it.pattern_length = len;
    command_queue = {command_queue, it};
    if (op == mpoc_pkg::OP_WR_BYTE) begin
      plan_pattern[slot][pos] = data;
      plan_written[slot][pos] = 1'b1;
    end else if (op == mpoc_pkg::OP_WR_LEN) begin
      plan_len[slot] = (len > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : len;
    end
    if (op <= mpoc_pkg::OP_READ) planned_count++;
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 8'h61 + 8'($urandom_range(0, 1));
    if (r < 80) return 8'h00;
    if (r < 85) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Fills any unwritten byte below the new length before the length itself is written.
  task automatic add_length(input logic [2:0] slot, input logic [4:0] len);
    int eff;
    eff = (len > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : len;
    for (int p = 0; p < eff; p++) begin
      if (!plan_written[slot][p]) begin
        push_item(mpoc_pkg::OP_WR_BYTE, slot, 4'(p), pick_text_byte(), 5'($urandom));
      end
    end
    push_item(mpoc_pkg::OP_WR_LEN, slot, 4'($urandom), 8'($urandom), len);
  endtask

  task automatic push_text(input logic [7:0] data);
    push_item(mpoc_pkg::OP_TEXT, 3'($urandom), 4'($urandom), data, 5'($urandom));
  endtask

  task automatic push_read(input logic [2:0] slot);
    push_item(mpoc_pkg::OP_READ, slot, 4'($urandom), 8'($urandom), 5'($urandom));
  endtask

  task automatic advance_shadow_counter(input mpoc_pkg::item_t it);
    count_beat_t res;
    int          len;
    bit          hit;
    case (it.operation)
      mpoc_pkg::OP_WR_BYTE: begin
        shadow_pattern[it.pattern_slot][it.byte_position] = it.data_byte;
      end
      mpoc_pkg::OP_WR_LEN: begin
        shadow_len[it.pattern_slot] = (it.pattern_length > MAX_PATTERN_LEN) ?
                                      5'(MAX_PATTERN_LEN) : it.pattern_length;
      end
      mpoc_pkg::OP_CLEAR: begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++) shadow_history[i] = '0;
        for (int s = 0; s < NUM_PATTERNS; s++) shadow_count[s] = '0;
        shadow_seen = 0;
      end
      mpoc_pkg::OP_TEXT: begin
        for (int i = MAX_PATTERN_LEN - 1; i > 0; i--) shadow_history[i] = shadow_history[i - 1];
        shadow_history[0] = it.data_byte;
        if (shadow_seen < MAX_PATTERN_LEN) shadow_seen++;
        for (int s = 0; s < NUM_PATTERNS; s++) begin
          len = shadow_len[s];
          hit = (len != 0) && (shadow_seen >= len);
          for (int i = 0; i < len; i++) begin
            if (shadow_pattern[s][len - 1 - i] != shadow_history[i]) hit = 1'b0;
          end
          if (hit && shadow_count[s] != '1) shadow_count[s]++;
        end
      end
      mpoc_pkg::OP_READ: begin
        res.count = shadow_count[it.pattern_slot];
        res.slot  = it.pattern_slot;
        expected_counts = {expected_counts, res};
      end
      default: ;
    endcase
  endtask

  // Driver: bursts of random length separated by random gaps.
  mpoc_pkg::item_t cur_item;
  int              burst_left = 0;
  int              gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_shadow_counter(cur_item);
        beats_in++;
        if (cur_item.operation == mpoc_pkg::OP_TEXT) text_beats++;
      end
      if (s_axis_tvalid && !s_axis_tready) stall_cycles++;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (command_queue.size() > 0) begin
          cur_item = command_queue.pop_front();
          s_axis_tdata  <= {4'b0, cur_item.pattern_length, cur_item.data_byte,
                            cur_item.byte_position, cur_item.pattern_slot};
          s_axis_tuser  <= cur_item.operation;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(50, 200);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left   = $urandom_range(0, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: alternating ready and stall runs, plus one long hold-off.
  int rx_cycles  = 0;
  int hold_left  = 0;
  int run_left   = 0;
  bit rx_ready   = 1'b1;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          rx_ready = !rx_ready;
          if (rx_ready) run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                                $urandom_range(1, 30);
          else run_left = $urandom_range(1, 12);
        end
        run_left--;
        m_axis_tready <= rx_ready;
      end
    end
  end

  // Monitor: every output beat is checked against the oldest predicted count.
  count_beat_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected beat count=%0d slot=%0d",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = expected_counts.pop_front();
        reads_checked++;
        if (m_axis_tdata !== want.count || m_axis_tuser !== want.slot) begin
          report_mismatch($sformatf("count=%0d slot=%0d, expected count=%0d slot=%0d",
                                    m_axis_tdata, m_axis_tuser, want.count, want.slot));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("multi_pattern_overlap_counter_core regression: fail");
      $finish;
    end
  end

  task automatic plan_rewrite();
    logic [2:0] slot;
    int         r;
    int         len;
    slot = 3'($urandom);
    r    = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 20) len = $urandom_range(MAX_PATTERN_LEN + 1, 31);
    else if (r < 35) len = $urandom_range(5, MAX_PATTERN_LEN);
    else len = $urandom_range(1, 4);
    for (int p = 0; p < len && p < MAX_PATTERN_LEN; p++) begin
      push_item(mpoc_pkg::OP_WR_BYTE, slot, 4'(p), pick_text_byte(), 5'($urandom));
    end
    add_length(slot, 5'(len));
  endtask

  task automatic plan_occurrence();
    logic [2:0] slot;
    int         reps;
    slot = 3'($urandom);
    if (plan_len[slot] == 0) begin
      push_text(pick_text_byte());
    end else begin
      reps = ($urandom_range(0, 9) < 3) ? 2 : 1;
      for (int k = 0; k < reps; k++) begin
        for (int p = 0; p < plan_len[slot]; p++) push_text(plan_pattern[slot][p]);
      end
      if ($urandom_range(0, 1) == 0) push_read(slot);
    end
  endtask

  initial begin
    int r;
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      plan_written[s] = '0;
      plan_len[s]     = 0;
      shadow_len[s]   = '0;
      shadow_count[s] = '0;
      for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
        plan_pattern[s][p]   = '0;
        shadow_pattern[s][p] = '0;
      end
    end
    for (int i = 0; i < MAX_PATTERN_LEN; i++) shadow_history[i] = '0;
    shadow_seen = 0;

    // Directed part: overlapping matches, extreme bytes and slots, an unused operation code, rewrite, clear, disable.
    push_read(3'd0);
    push_item(mpoc_pkg::OP_WR_BYTE, 3'd0, 4'd0, 8'h41, 5'($urandom));
    push_item(mpoc_pkg::OP_WR_BYTE, 3'd0, 4'd1, 8'h41, 5'($urandom));
    add_length(3'd0, 5'd2);
    push_item(mpoc_pkg::OP_WR_BYTE, 3'd7, 4'd0, 8'hFF, 5'($urandom));
    push_item(mpoc_pkg::OP_WR_BYTE, 3'd7, 4'd15, 8'h00, 5'($urandom));
    add_length(3'd7, 5'd1);
    push_item(mpoc_pkg::OP_WR_BYTE, 3'd1, 4'd0, 8'h00, 5'($urandom));
    push_item(mpoc_pkg::OP_WR_BYTE, 3'd1, 4'd1, 8'h00, 5'($urandom));
    add_length(3'd1, 5'd2);
    repeat (4) push_text(8'h41);
    repeat (2) push_text(8'hFF);
    push_read(3'd0);
    push_read(3'd7);
    push_item(3'(OP_CODE_MAX), 3'($urandom), 4'($urandom), 8'($urandom), 5'($urandom));
    push_item(mpoc_pkg::OP_WR_BYTE, 3'd0, 4'd1, 8'h42, 5'($urandom));
    push_text(8'h41);
    push_text(8'h42);
    push_read(3'd0);
    push_item(mpoc_pkg::OP_CLEAR, 3'($urandom), 4'($urandom), 8'($urandom), 5'($urandom));
    push_text(8'h00);
    push_read(3'd1);
    push_text(8'h00);
    push_read(3'd1);
    add_length(3'd7, 5'd0);
    push_text(8'hFF);
    push_read(3'd7);

    // Random part: mostly random text and embedded pattern occurrences, plus reads, rewrites and clears.
    while (planned_count < PLANNED_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) plan_rewrite();
      else if (r < 12) push_item(mpoc_pkg::OP_WR_BYTE, 3'($urandom), 4'($urandom),
                                 8'($urandom), 5'($urandom));
      else if (r < 14) push_item(mpoc_pkg::OP_CLEAR, 3'($urandom), 4'($urandom),
                                 8'($urandom), 5'($urandom));
      else if (r < 17) push_item(3'($urandom_range(int'(mpoc_pkg::OP_READ) + 1, OP_CODE_MAX)),
                                 3'($urandom), 4'($urandom), 8'($urandom), 5'($urandom));
      else if (r < 30) push_read(3'($urandom));
      else if (r < 60) plan_occurrence();
      else push_text(pick_text_byte());
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (command_queue.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d input beats (%0d text bytes) and %0d checked count reads",
             beats_in, text_beats, reads_checked);
    $display("input stalled for %0d cycles, with one %0d-cycle receiver hold-off",
             stall_cycles, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("multi_pattern_overlap_counter_core regression: pass");
    end else begin
      $display("%0d mismatches", err_count);
      $display("multi_pattern_overlap_counter_core regression: fail");
    end
    $finish;
  end

endmodule
